FILE: hw/rtl/packet_sequence_loss_monitor_defines.svh
// ----------------------------------------------------------------------------
// Packet sequence loss monitor: assertion macros
// Assertion forms for the checker file of the loss monitor.
// ----------------------------------------------------------------------------
`ifndef PACKET_SEQUENCE_LOSS_MONITOR_DEFINES_SVH
`define PACKET_SEQUENCE_LOSS_MONITOR_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define PSLM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PSLM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/pslm_pkg.sv
// ----------------------------------------------------------------------------
// Packet sequence loss monitor package
// Widths and the structs passed between the stage logic and the state core.
// ----------------------------------------------------------------------------
package pslm_pkg;

  localparam int unsigned SeqW = 64;
  localparam int unsigned CntW = 64;

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_CLOSE  = 1'b1
  } kind_e;

  // Item handed to the state core in the cycle it leaves the input stage
  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [SeqW-1:0] seq;
  } pslm_cmd_t;

  typedef struct packed {
    logic            out_of_order;
    logic [SeqW-1:0] highest_seen;
    logic [CntW-1:0] interval_received;
    logic [CntW-1:0] interval_misordered;
    logic [CntW-1:0] interval_lost;
    logic [CntW-1:0] total_received;
    logic [CntW-1:0] total_misordered;
    logic [CntW-1:0] total_lost;
  } pslm_result_t;

endpackage

FILE: hw/rtl/pslm_state.sv
// ----------------------------------------------------------------------------
// Packet sequence loss monitor state core
// Holds the flow counters and forms the result of the item being committed.
// ----------------------------------------------------------------------------
module pslm_state
  import pslm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pslm_cmd_t    cmd_i,
  output pslm_result_t result_o
);

  logic [SeqW-1:0] highest_q, highest_d;
  logic [CntW-1:0] irecv_q, irecv_d;
  logic [CntW-1:0] iooo_q, iooo_d;
  logic [CntW-1:0] trecv_q, trecv_d;
  logic [CntW-1:0] tooo_q, tooo_d;
  logic [CntW-1:0] tloss_q, tloss_d;
  logic [CntW-1:0] last_loss_q, last_loss_d;

  logic [SeqW-1:0] expected;
  logic            is_expected;
  logic            is_above;
  logic [CntW:0]   tloss_diff;
  logic [CntW-1:0] tloss_new;
  logic [CntW:0]   iloss_diff;
  logic [CntW-1:0] iloss_new;

  assign expected    = highest_q + SeqW'(1);
  assign is_expected = (cmd_i.seq == expected);
  assign is_above    = (cmd_i.seq > expected);

  // Saturate both losses at zero: the borrow bit flags a negative difference
  assign tloss_diff = {1'b0, highest_q} - {1'b0, trecv_q};
  assign tloss_new  = tloss_diff[CntW] ? '0 : tloss_diff[CntW-1:0];
  assign iloss_diff = {1'b0, tloss_new} - {1'b0, last_loss_q};
  assign iloss_new  = iloss_diff[CntW] ? '0 : iloss_diff[CntW-1:0];

  always_comb begin
    highest_d   = highest_q;
    irecv_d     = irecv_q;
    iooo_d      = iooo_q;
    trecv_d     = trecv_q;
    tooo_d      = tooo_q;
    tloss_d     = tloss_q;
    last_loss_d = last_loss_q;
    case (cmd_i.kind)
      KIND_PACKET: begin
        irecv_d = irecv_q + CntW'(1);
        trecv_d = trecv_q + CntW'(1);
        if (is_expected || is_above) begin
          highest_d = cmd_i.seq;
        end
        if (!is_expected) begin
          iooo_d = iooo_q + CntW'(1);
          tooo_d = tooo_q + CntW'(1);
        end
      end
      KIND_CLOSE: begin
        irecv_d     = '0;
        iooo_d      = '0;
        tloss_d     = tloss_new;
        last_loss_d = tloss_new;
      end
      default: begin
        highest_d = highest_q;
      end
    endcase
  end

  always_comb begin
    result_o.highest_seen     = highest_d;
    result_o.total_received   = trecv_d;
    result_o.total_misordered = tooo_d;
    result_o.total_lost       = tloss_d;
    if (cmd_i.kind == KIND_CLOSE) begin
      // Report the interval figures as they stood before the clear
      result_o.out_of_order        = 1'b0;
      result_o.interval_received   = irecv_q;
      result_o.interval_misordered = iooo_q;
      result_o.interval_lost       = iloss_new;
    end else begin
      result_o.out_of_order        = !is_expected;
      result_o.interval_received   = irecv_d;
      result_o.interval_misordered = iooo_d;
      result_o.interval_lost       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q   <= '0;
      irecv_q     <= '0;
      iooo_q      <= '0;
      trecv_q     <= '0;
      tooo_q      <= '0;
      tloss_q     <= '0;
      last_loss_q <= '0;
    end else if (cmd_i.valid) begin
      highest_q   <= highest_d;
      irecv_q     <= irecv_d;
      iooo_q      <= iooo_d;
      trecv_q     <= trecv_d;
      tooo_q      <= tooo_d;
      tloss_q     <= tloss_d;
      last_loss_q <= last_loss_d;
    end
  end

endmodule

FILE: hw/rtl/packet_sequence_loss_monitor.sv
// ----------------------------------------------------------------------------
// Packet sequence loss monitor
// Counts receptions, misordering and loss of one flow's sequence numbers.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o | kind_i, seq_number_i
//   out     | output    | out_valid_o/out_ready_i | out_of_order_o .. total_lost_o
//
// One item per cycle sustained while results are taken; each item passes the
// input register, then the state update into the result register.
// Throughput is set by the single 64-bit compare/increment pass of the state core.
// Reset clears all counters and the highest sequence number to zero.
// A stalled result holds the result register; the input register still takes
// one more item, after which in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module packet_sequence_loss_monitor
  import pslm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            kind_i,
  input  logic [SeqW-1:0] seq_number_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_of_order_o,
  output logic [SeqW-1:0] highest_seen_o,
  output logic [CntW-1:0] interval_received_o,
  output logic [CntW-1:0] interval_misordered_o,
  output logic [CntW-1:0] interval_lost_o,
  output logic [CntW-1:0] total_received_o,
  output logic [CntW-1:0] total_misordered_o,
  output logic [CntW-1:0] total_lost_o
);

  logic            in_valid_q;
  kind_e           kind_q;
  logic [SeqW-1:0] seq_q;
  logic            advance;
  pslm_cmd_t       cmd;
  pslm_result_t    result;
  pslm_result_t    result_q;
  logic            out_valid_q;

  // Advance the held item whenever the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign cmd.valid = advance;
  assign cmd.kind  = kind_q;
  assign cmd.seq   = seq_q;

  pslm_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_e'(kind_i);
      seq_q  <= seq_number_i;
    end
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_of_order_o        = result_q.out_of_order;
  assign highest_seen_o        = result_q.highest_seen;
  assign interval_received_o   = result_q.interval_received;
  assign interval_misordered_o = result_q.interval_misordered;
  assign interval_lost_o       = result_q.interval_lost;
  assign total_received_o      = result_q.total_received;
  assign total_misordered_o    = result_q.total_misordered;
  assign total_lost_o          = result_q.total_lost;

endmodule

FILE: hw/rtl/pslm_checker.sv
// ----------------------------------------------------------------------------
// Packet sequence loss monitor checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_sequence_loss_monitor_defines.svh"

module pslm_checker
  import pslm_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            out_of_order_o,
  input logic [SeqW-1:0] highest_seen_o,
  input logic [CntW-1:0] interval_received_o,
  input logic [CntW-1:0] interval_misordered_o,
  input logic [CntW-1:0] interval_lost_o,
  input logic [CntW-1:0] total_received_o,
  input logic [CntW-1:0] total_misordered_o,
  input logic [CntW-1:0] total_lost_o
);

  logic [SeqW+6*CntW:0] out_payload;
  assign out_payload = {out_of_order_o, highest_seen_o, interval_received_o,
                        interval_misordered_o, interval_lost_o, total_received_o,
                        total_misordered_o, total_lost_o};

  // A stalled result holds its value
  `PSLM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_payload), "result changed while stalled")

  // Only a close reports loss, and a close is never misordered
  `PSLM_ASSERT(a_loss_on_close, clk_i, rst_ni, out_valid_o && (interval_lost_o != '0) |-> !out_of_order_o, "loss reported on a misordered packet")

  // Interval loss is a part of total loss
  `PSLM_ASSERT(a_loss_bound, clk_i, rst_ni, out_valid_o |-> interval_lost_o <= total_lost_o, "interval loss above total loss")

  // Nothing is shown once reset has been seen low
  `PSLM_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind packet_sequence_loss_monitor pslm_checker u_pslm_checker (.*);
